FILE: design/mcrf_pkg.sv
package mcrf_pkg;

	localparam int DEPTH       = 64;
	localparam int CHANNELS    = 3;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STORE_DEPTH = CHANNELS * DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int DATA_W  = 8;
	localparam int CNT_W   = 8;
	localparam int OPC_W   = 3;
	localparam int CHF_W   = 2;
	localparam int AVAIL_W = 6;

	// command queue between front and back
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_IDX_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_FILL_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

	localparam logic [OPC_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OPC_W-1:0] OP_POP    = 3'd1;
	localparam logic [OPC_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OPC_W-1:0] OP_PEEKN  = 3'd3;
	localparam logic [OPC_W-1:0] OP_LINE   = 3'd4;
	localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;

	typedef enum logic [2:0] {
		K_PUSH,
		K_POP,
		K_PEEK,
		K_PEEKN,
		K_LINE,
		K_CLEAR,
		K_NOP,
		K_BAD_CH
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CH_W-1:0]   ch;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} back_state_t;

endpackage

FILE: design/mcrf_in_if.sv
interface mcrf_in_if;
	import mcrf_pkg::*;

	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [CHF_W-1:0]  channel;
	logic [DATA_W-1:0] data_in;
	logic [CNT_W-1:0]  count;

	modport source (output valid, opcode, channel, data_in, count, input ready);
	modport sink (input valid, opcode, channel, data_in, count, output ready);

endinterface

FILE: design/mcrf_out_if.sv
interface mcrf_out_if;
	import mcrf_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  data_out;
	logic               valid_res;
	logic [AVAIL_W-1:0] available;
	logic               last;

	modport source (output valid, data_out, valid_res, available, last, input ready);
	modport sink (input valid, data_out, valid_res, available, last, output ready);

endinterface

FILE: design/mcrf_ram.sv
module mcrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last word when no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/mcrf_front.sv
module mcrf_front (
	input  logic           clk,
	input  logic           arst_n,
	mcrf_in_if.sink        req,
	output mcrf_pkg::cmd_t head,
	output logic           head_valid,
	input  logic           head_pop
);
	import mcrf_pkg::*;

	cmd_t                   mem_q [CMDQ_DEPTH];
	logic [CMDQ_IDX_W-1:0]  wr_idx_q;
	logic [CMDQ_IDX_W-1:0]  rd_idx_q;
	logic [CMDQ_FILL_W-1:0] fill_q;
	cmd_t                   cls;
	logic                   push;
	logic                   pop;

	always_comb begin
		cls.ch    = CH_W'(req.channel);
		cls.data  = req.data_in;
		cls.count = req.count;
		unique case (req.opcode)
			OP_PUSH:  cls.kind = K_PUSH;
			OP_POP:   cls.kind = K_POP;
			OP_PEEK:  cls.kind = K_PEEK;
			OP_PEEKN: cls.kind = K_PEEKN;
			OP_LINE:  cls.kind = K_LINE;
			OP_CLEAR: cls.kind = K_CLEAR;
			default:  cls.kind = K_NOP;
		endcase
		// an out-of-range channel overrides any opcode
		if (int'(req.channel) >= CHANNELS) begin
			cls.kind = K_BAD_CH;
			cls.ch   = '0;
		end
	end

	assign req.ready  = (fill_q != CMDQ_FILL_W'(CMDQ_DEPTH));
	assign push       = req.valid && req.ready;
	assign head_valid = (fill_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = mem_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_idx_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= (wr_idx_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (pop) begin
				rd_idx_q <= (rd_idx_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + CMDQ_FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CMDQ_FILL_W'(1);
			end
		end
	end

endmodule

FILE: design/mcrf_back.sv
module mcrf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mcrf_pkg::cmd_t head,
	input  logic           head_valid,
	output logic           head_pop,
	mcrf_out_if.source     rsp
);
	import mcrf_pkg::*;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] held_of(input logic [PTR_W-1:0] w,
			input logic [PTR_W-1:0] r);
		logic [PTR_W:0] t;
		if (w >= r) begin
			t = {1'b0, w} - {1'b0, r};
		end else begin
			t = {1'b0, w} + (PTR_W+1)'(DEPTH) - {1'b0, r};
		end
		return t[PTR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] c,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(c) * ADDR_W'(DEPTH) + ADDR_W'(p);
	endfunction

	back_state_t       state_q, state_d;
	cmd_t              cur_q;
	logic [PTR_W-1:0]  wr_ptr_q [CHANNELS];
	logic [PTR_W-1:0]  rd_ptr_q [CHANNELS];
	logic [PTR_W-1:0]  scan_q, scan_d;
	logic [PTR_W-1:0]  remain_q, remain_d;
	logic [PTR_W-1:0]  line_i_q, line_i_d;
	logic [PTR_W-1:0]  avail_q, avail_d;

	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_vres_q;
	logic [AVAIL_W-1:0] out_avail_q;
	logic               out_last_q;

	logic               out_free;
	logic               start;
	logic               load_cur;
	logic [CH_W-1:0]    sel_ch;
	logic [PTR_W-1:0]   w_sel, r_sel, held_sel, n_peek;
	logic [PTR_W-1:0]   line_i_next;
	logic               idle_read;
	logic               peek_cont, line_cont, run_more;

	logic               load;
	logic [DATA_W-1:0]  res_data;
	logic               res_vres;
	logic [AVAIL_W-1:0] res_avail;
	logic               res_last;
	logic               wr_upd, rd_upd;
	logic [PTR_W-1:0]   wr_val, rd_val;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	mcrf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (head.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign start    = (state_q == ST_IDLE) && head_valid && out_free;
	assign sel_ch   = (state_q == ST_IDLE) ? head.ch : cur_q.ch;
	assign w_sel    = wr_ptr_q[sel_ch];
	assign r_sel    = rd_ptr_q[sel_ch];
	assign held_sel = held_of(w_sel, r_sel);
	assign n_peek   = (CNT_W'(held_sel) < head.count) ? held_sel : PTR_W'(head.count);

	always_comb begin
		case (head.kind)
			K_POP, K_PEEK: idle_read = (held_sel != '0);
			K_PEEKN:       idle_read = (n_peek != '0);
			K_LINE:        idle_read = (held_sel != '0) && (head.count > CNT_W'(1));
			default:       idle_read = 1'b0;
		endcase
	end

	assign line_i_next = line_i_q + 1'b1;
	assign peek_cont   = (remain_q != PTR_W'(1));
	// stop a line on newline, on an empty channel, or when count - 1 bytes are taken
	assign line_cont   = (held_sel != PTR_W'(1))
		&& (CNT_W'(line_i_next) < cur_q.count - CNT_W'(1))
		&& (ram_rdata != NEWLINE);

	always_comb begin
		case (cur_q.kind)
			K_PEEKN: run_more = peek_cont;
			K_LINE:  run_more = line_cont;
			default: run_more = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && idle_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (out_free && !run_more) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		head_pop  = 1'b0;
		load_cur  = 1'b0;
		load      = 1'b0;
		res_data  = '0;
		res_vres  = 1'b0;
		res_avail = '0;
		res_last  = 1'b1;
		wr_upd    = 1'b0;
		rd_upd    = 1'b0;
		wr_val    = next_ptr(w_sel);
		rd_val    = next_ptr(r_sel);
		ram_we    = 1'b0;
		ram_waddr = addr_of(sel_ch, w_sel);
		ram_re    = 1'b0;
		ram_raddr = addr_of(sel_ch, r_sel);
		scan_d    = scan_q;
		remain_d  = remain_q;
		line_i_d  = line_i_q;
		avail_d   = avail_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					head_pop = 1'b1;
					load_cur = 1'b1;
					load     = !idle_read;
					case (head.kind)
						K_PUSH: begin
							if (next_ptr(w_sel) != r_sel) begin
								ram_we    = 1'b1;
								wr_upd    = 1'b1;
								res_vres  = 1'b1;
								res_avail = AVAIL_W'(held_sel) + AVAIL_W'(1);
							end else begin
								res_avail = AVAIL_W'(held_sel);
							end
						end
						K_POP, K_PEEK: begin
							ram_re = idle_read;
						end
						K_PEEKN: begin
							ram_re    = idle_read;
							scan_d    = next_ptr(r_sel);
							remain_d  = n_peek;
							avail_d   = held_sel;
							res_avail = AVAIL_W'(held_sel);
						end
						K_LINE: begin
							ram_re    = idle_read;
							line_i_d  = '0;
							res_avail = AVAIL_W'(held_sel);
						end
						K_CLEAR: begin
							rd_upd = 1'b1;
							rd_val = w_sel;
						end
						K_NOP: begin
							res_avail = AVAIL_W'(held_sel);
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					load     = 1'b1;
					res_data = ram_rdata;
					res_vres = 1'b1;
					case (cur_q.kind)
						K_POP: begin
							rd_upd    = 1'b1;
							res_avail = AVAIL_W'(held_sel) - AVAIL_W'(1);
						end
						K_PEEK: begin
							res_avail = AVAIL_W'(held_sel);
						end
						K_PEEKN: begin
							res_avail = AVAIL_W'(avail_q);
							res_last  = !peek_cont;
							remain_d  = remain_q - 1'b1;
							if (peek_cont) begin
								ram_re    = 1'b1;
								ram_raddr = addr_of(sel_ch, scan_q);
								scan_d    = next_ptr(scan_q);
							end
						end
						K_LINE: begin
							rd_upd    = 1'b1;
							res_avail = AVAIL_W'(held_sel) - AVAIL_W'(1);
							res_last  = !line_cont;
							line_i_d  = line_i_next;
							if (line_cont) begin
								ram_re    = 1'b1;
								ram_raddr = addr_of(sel_ch, next_ptr(r_sel));
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data_out  = out_data_q;
	assign rsp.valid_res = out_vres_q;
	assign rsp.available = out_avail_q;
	assign rsp.last      = out_last_q;

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= head;
		end
		if (load) begin
			out_data_q  <= res_data;
			out_vres_q  <= res_vres;
			out_avail_q <= res_avail;
			out_last_q  <= res_last;
		end
		scan_q   <= scan_d;
		remain_q <= remain_d;
		line_i_q <= line_i_d;
		avail_q  <= avail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wr_ptr_q[i] <= '0;
				rd_ptr_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_upd) begin
				wr_ptr_q[sel_ch] <= wr_val;
			end
			if (rd_upd) begin
				rd_ptr_q[sel_ch] <= rd_val;
			end
		end
	end

endmodule

FILE: design/multi_channel_rx_fifo.sv
// channel | dir | handshake   | word
// req     | in  | valid/ready | opcode, channel, data_in, count
// rsp     | out | valid/ready | data_out, valid_res, available, last
//
// A request word enters a two-word command queue, then the executor runs it.
// Push, clear and no-op words finish in the idle state; pop and peek on a non-empty
// channel read the store, then give the result. Peek n and get line give one result
// word per cycle after the first read while rsp is ready; the store's registered read
// port sets that pace. Reset clears all pointers; the byte store is not cleared.
// Either side may stall: a full queue drops req.ready, a held rsp word stalls the executor.
module multi_channel_rx_fifo (
	input  logic       clk,
	input  logic       arst_n,
	mcrf_in_if.sink    req,
	mcrf_out_if.source rsp
);
	import mcrf_pkg::*;

	cmd_t head;
	logic head_valid;
	logic head_pop;

	mcrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	mcrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.rsp        (rsp)
	);

endmodule

FILE: bench/multi_channel_rx_fifo_tb.sv
`timescale 1ns / 100ps

module multi_channel_rx_fifo_tb;
	import mcrf_pkg::*;

	localparam logic [OPC_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OPC_W-1:0] OP_RSVD7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_WORDS   = 80;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic               valid_res;
		logic [AVAIL_W-1:0] available;
		logic               last;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mcrf_in_if  req_if ();
	mcrf_out_if rsp_if ();

	multi_channel_rx_fifo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the channel buffers
	logic [DATA_W-1:0] fifo_mem [CHANNELS][DEPTH];
	logic [PTR_W-1:0]  wr_ptr [CHANNELS];
	logic [PTR_W-1:0]  rd_ptr [CHANNELS];

	rsp_word_t   due_words [$];
	int unsigned err_count   = 0;
	int unsigned send_idle   = 0;
	int unsigned recv_idle   = 0;
	bit          hold_on     = 1'b0;
	int unsigned quiet_count = 0;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (int'(p) + 1 >= DEPTH) ? '0 : p + 1'b1;
	endfunction

	function automatic int unsigned fill_level(input int ch);
		return (int'(wr_ptr[ch]) + DEPTH - int'(rd_ptr[ch])) % DEPTH;
	endfunction

	function automatic void queue_word(input logic [DATA_W-1:0] data, input logic vld,
			input int unsigned avail, input logic last);
		rsp_word_t w;
		w.data      = data;
		w.valid_res = vld;
		w.available = avail[AVAIL_W-1:0];
		w.last      = last;
		due_words.push_back(w);
	endfunction

	// work out the result words one request word causes, and update the shadow state
	function automatic void run_fifo_op(input logic [OPC_W-1:0] op, input logic [CHF_W-1:0] ch,
			input logic [DATA_W-1:0] din, input logic [CNT_W-1:0] cnt);
		int unsigned       lvl;
		int unsigned       n;
		int unsigned       i;
		logic [PTR_W-1:0]  r;
		logic [DATA_W-1:0] b;
		bit                stop;
		bit                have_pend;
		rsp_word_t         pend;
		if (ch >= CHANNELS) begin
			queue_word('0, 1'b0, 0, 1'b1);
			return;
		end
		lvl = fill_level(ch);
		case (op)
			OP_PUSH: begin
				if (ptr_inc(wr_ptr[ch]) != rd_ptr[ch]) begin
					fifo_mem[ch][wr_ptr[ch]] = din;
					wr_ptr[ch] = ptr_inc(wr_ptr[ch]);
					queue_word('0, 1'b1, fill_level(ch), 1'b1);
				end else begin
					queue_word('0, 1'b0, lvl, 1'b1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (lvl == 0) begin
					queue_word('0, 1'b0, 0, 1'b1);
				end else begin
					b = fifo_mem[ch][rd_ptr[ch]];
					if (op == OP_POP)
						rd_ptr[ch] = ptr_inc(rd_ptr[ch]);
					queue_word(b, 1'b1, fill_level(ch), 1'b1);
				end
			end
			OP_PEEKN: begin
				n = (cnt < lvl) ? cnt : lvl;
				r = rd_ptr[ch];
				for (i = 0; i < n; i++) begin
					queue_word(fifo_mem[ch][r], 1'b1, lvl, i + 1 == n);
					r = ptr_inc(r);
				end
				if (n == 0)
					queue_word('0, 1'b0, lvl, 1'b1);
			end
			OP_LINE: begin
				i = 0;
				stop = 1'b0;
				have_pend = 1'b0;
				// hold each word back until we know whether it is the last one
				while (!stop && fill_level(ch) != 0 && cnt != 0 && int'(i) < int'(cnt) - 1) begin
					b = fifo_mem[ch][rd_ptr[ch]];
					rd_ptr[ch] = ptr_inc(rd_ptr[ch]);
					i++;
					if (have_pend)
						due_words.push_back(pend);
					pend.data      = b;
					pend.valid_res = 1'b1;
					pend.available = AVAIL_W'(fill_level(ch));
					pend.last      = 1'b0;
					have_pend = 1'b1;
					if (b == NEWLINE)
						stop = 1'b1;
				end
				if (have_pend) begin
					pend.last = 1'b1;
					due_words.push_back(pend);
				end else begin
					queue_word('0, 1'b0, fill_level(ch), 1'b1);
				end
			end
			OP_CLEAR: begin
				rd_ptr[ch] = wr_ptr[ch];
				queue_word('0, 1'b0, 0, 1'b1);
			end
			default: queue_word('0, 1'b0, lvl, 1'b1);
		endcase
	endfunction

	task automatic send_word(input logic [OPC_W-1:0] op, input logic [CHF_W-1:0] ch,
			input logic [DATA_W-1:0] din, input logic [CNT_W-1:0] cnt);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.opcode  <= op;
		req_if.channel <= ch;
		req_if.data_in <= din;
		req_if.count   <= cnt;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		run_fifo_op(op, ch, din, cnt);
	endtask

	// receiver: check each word against the oldest expectation, then pick the next ready
	always @(posedge clk) begin : rsp_check
		rsp_word_t exp_w;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (due_words.size() == 0) begin
				$error("unexpected result word: data_out %0h valid_res %0b available %0d last %0b",
					rsp_if.data_out, rsp_if.valid_res, rsp_if.available, rsp_if.last);
				err_count++;
			end else begin
				exp_w = due_words.pop_front();
				if (rsp_if.data_out !== exp_w.data) begin
					$error("data_out: expected %0h, got %0h", exp_w.data, rsp_if.data_out);
					err_count++;
				end
				if (rsp_if.valid_res !== exp_w.valid_res) begin
					$error("valid_res: expected %0b, got %0b", exp_w.valid_res, rsp_if.valid_res);
					err_count++;
				end
				if (rsp_if.available !== exp_w.available) begin
					$error("available: expected %0d, got %0d", exp_w.available, rsp_if.available);
					err_count++;
				end
				if (rsp_if.last !== exp_w.last) begin
					$error("last: expected %0b, got %0b", exp_w.last, rsp_if.last);
					err_count++;
				end
			end
		end
		rsp_if.ready <= !hold_on && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= WATCHDOG_LIMIT) begin
			$error("watchdog: no word moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, due_words.size());
			$display("** multi_channel_rx_fifo: FAILED **");
			$finish;
		end
	end

	task automatic test_empty_channel();
		send_word(OP_POP, 2'd0, 8'h00, 8'h00);
		send_word(OP_PEEK, 2'd0, 8'h00, 8'h00);
		send_word(OP_PEEKN, 2'd0, 8'h00, 8'd5);
		send_word(OP_LINE, 2'd0, 8'h00, 8'hFF);
		send_word(OP_CLEAR, 2'd0, 8'h00, 8'h00);
		send_word(OP_PUSH, CHF_W'(CHANNELS), 8'hFF, 8'hFF);
		send_word(OP_RSVD6, 2'd1, 8'hFF, 8'hFF);
		send_word(OP_RSVD7, 2'd1, 8'h00, 8'h00);
	endtask

	task automatic test_line_and_peek();
		send_word(OP_PUSH, 2'd0, 8'h00, 8'h00);
		send_word(OP_PUSH, 2'd0, 8'hFF, 8'hFF);
		send_word(OP_PUSH, 2'd0, NEWLINE, 8'h00);
		send_word(OP_PUSH, 2'd0, 8'h41, 8'h00);
		send_word(OP_PEEK, 2'd0, 8'h00, 8'h00);
		send_word(OP_PEEKN, 2'd0, 8'h00, 8'd0);
		send_word(OP_PEEKN, 2'd0, 8'h00, 8'hFF);
		send_word(OP_LINE, 2'd0, 8'h00, 8'd1);
		send_word(OP_LINE, 2'd0, 8'h00, 8'd0);
		// stop on the newline, which is included
		send_word(OP_LINE, 2'd0, 8'h00, 8'hFF);
		send_word(OP_POP, 2'd0, 8'h00, 8'h00);
		send_word(OP_POP, 2'd0, 8'h00, 8'h00);
		send_word(OP_PUSH, 2'd1, 8'h55, 8'h00);
		send_word(OP_PUSH, 2'd1, 8'hAA, 8'h00);
		send_word(OP_LINE, 2'd1, 8'h00, 8'd2);
		send_word(OP_CLEAR, 2'd1, 8'h00, 8'h00);
	endtask

	task automatic test_full_under_backpressure();
		int i;
		send_idle = 0;
		// hold the receiver off while the sender keeps pushing
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		// one more push than the channel holds: the last one is dropped
		for (i = 0; i < DEPTH; i++)
			send_word(OP_PUSH, 2'd2, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(255)));
		send_word(OP_PEEKN, 2'd2, 8'h00, 8'hFF);
		for (i = 0; i < 3; i++)
			send_word(OP_POP, 2'd2, 8'h00, 8'h00);
		// wrap the write pointer
		for (i = 0; i < 3; i++)
			send_word(OP_PUSH, 2'd2, DATA_W'($urandom_range(255)), 8'h00);
		send_word(OP_PEEKN, 2'd2, 8'h00, 8'hFF);
		send_word(OP_LINE, 2'd2, 8'h00, 8'd4);
		send_word(OP_CLEAR, 2'd2, 8'h00, 8'h00);
		send_word(OP_PEEK, 2'd2, 8'h00, 8'h00);
	endtask

	task automatic run_random_words(input int unsigned n_words);
		int unsigned       done_cnt;
		int unsigned       roll;
		logic [OPC_W-1:0]  op;
		logic [CHF_W-1:0]  ch;
		logic [DATA_W-1:0] din;
		logic [CNT_W-1:0]  cnt;
		done_cnt = 0;
		while (done_cnt < n_words) begin
			roll = $urandom_range(99);
			ch = CHF_W'($urandom_range(CHANNELS - 1));
			if (roll < 45)
				op = OP_PUSH;
			else if (roll < 60)
				op = OP_POP;
			else if (roll < 67)
				op = OP_PEEK;
			else if (roll < 79)
				op = OP_PEEKN;
			else if (roll < 92)
				op = OP_LINE;
			else if (roll < 95)
				op = OP_CLEAR;
			else if (roll < 98)
				op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
			else begin
				op = OPC_W'($urandom_range(7));
				ch = CHF_W'(CHANNELS);
			end
			din = ($urandom_range(99) < 15) ? NEWLINE : DATA_W'($urandom_range(255));
			cnt = ($urandom_range(99) < 60) ? CNT_W'($urandom_range(8)) : CNT_W'($urandom_range(255));
			send_word(op, ch, din, cnt);
			if (op <= OP_CLEAR && ch < CHANNELS)
				done_cnt++;
		end
	endtask

	task automatic test_random_traffic();
		send_idle = 16;
		recv_idle = 67;
		run_random_words(RANDOM_WORDS);
		send_idle = 67;
		recv_idle = 16;
		run_random_words(RANDOM_WORDS);
		send_idle = 0;
		recv_idle = 0;
		run_random_words(RANDOM_WORDS);
	endtask

	initial begin
		int ch;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.opcode  = OP_PUSH;
		req_if.channel = '0;
		req_if.data_in = '0;
		req_if.count   = '0;
		rsp_if.ready   = 1'b0;
		for (ch = 0; ch < CHANNELS; ch++) begin
			wr_ptr[ch] = '0;
			rd_ptr[ch] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 16;
		recv_idle = 67;
		test_empty_channel();
		test_line_and_peek();
		test_full_under_backpressure();
		test_random_traffic();

		req_if.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("** multi_channel_rx_fifo: PASSED **");
		else
			$display("** multi_channel_rx_fifo: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
design/mcrf_pkg.sv
design/mcrf_in_if.sv
design/mcrf_out_if.sv
design/mcrf_ram.sv
design/mcrf_front.sv
design/mcrf_back.sv
design/multi_channel_rx_fifo.sv
bench/multi_channel_rx_fifo_tb.sv
